// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by weighted_binning_histogram.
// No dependencies; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, off while reset is held.
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define CHK_IMPL(lbl, ante, cons, msg) \
  `CHK_PROP(lbl, (ante) |-> (cons), msg)

// Implication checked in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
  `CHK_PROP(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/whb_pkg.sv =====
// Package for the weighted binning histogram: sizes, codes and types.
// No dependencies.
`timescale 1ns / 1ps

package whb_pkg;

  localparam int MAX_BINS = 1024;
  localparam int BIN_AW   = $clog2(MAX_BINS);
  localparam int CNT_W    = 11;   // width of the bins_in_use register
  localparam int TOT_W    = 48;
  localparam int NUM_W    = 34;   // 2*diff + width
  localparam int DEN_W    = 33;   // 2*width
  localparam int CFG_AW   = 2;

  typedef enum logic [1:0] {
    CMD_ACC  = 2'd0,
    CMD_CLR  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_DIR   = 2'd0,
    REG_LOW   = 2'd1,
    REG_WIDTH = 2'd2,
    REG_BINS  = 2'd3
  } reg_idx_t;

endpackage

// ===== hw/rtl/weighted_binning_histogram.sv =====
// Weighted histogram over 1024 bins of 48-bit Q32.16 totals held in one
// single-port synchronous RAM. One word is worked at a time: an accumulate
// finds its bin in the bit-serial divider, then reads the RAM, writes back
// and loads the output register, or gives an error word at once for a
// sample below the low edge; a read goes through the RAM read to the
// output register; a clear sweeps the RAM at one bin per cycle, then
// returns. A result waits while the output stalls; the next word is taken
// in the cycle after a result is loaded. After reset all bins are cleared
// with no result before the first word; config writes are always accepted.
// Depends on whb_pkg, whb_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_binning_histogram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic signed [31:0]         in_sample_value,
  input  logic [31:0]                in_sample_weight,
  input  logic [9:0]                 in_read_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [9:0]                 out_bin_number,
  output logic [whb_pkg::TOT_W-1:0]  out_bin_total,
  output logic                       out_below_low_error,
  input  logic                       cfg_we,
  input  logic [whb_pkg::CFG_AW-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import whb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_MOD  = 6'b001000,
    ST_CLR  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(MAX_BINS - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BINS);
  localparam logic [TOT_W:0]    TOT_MAX  = {1'b0, {TOT_W{1'b1}}};

  // configuration
  logic              dir_r;
  logic [31:0]       low_r;
  logic [31:0]       width_r;
  logic [CNT_W-1:0]  bins_r;

  // control and item state
  state_t            state_r, state_nxt;
  logic [BIN_AW-1:0] addr_r, addr_nxt;
  logic              acc_r, acc_nxt;
  logic              report_r, report_nxt;
  logic [31:0]       w_r, w_nxt;
  logic [BIN_AW-1:0] res_bin_r, res_bin_nxt;
  logic [TOT_W-1:0]  res_tot_r, res_tot_nxt;
  logic              res_err_r, res_err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BIN_AW-1:0] out_bin_r, out_bin_nxt;
  logic [TOT_W-1:0]  out_tot_r, out_tot_nxt;
  logic              out_err_r, out_err_nxt;

  // bin RAM
  logic [TOT_W-1:0]  mem [MAX_BINS];
  logic [TOT_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [TOT_W-1:0]  mem_wdata;
  logic              mem_re;

  // datapath
  logic signed [33:0] sval;
  logic signed [33:0] lval;
  logic signed [33:0] diff;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quo;
  logic               div_start;
  logic               div_done;
  logic [CNT_W-1:0]   n_act;
  logic [CNT_W-1:0]   n_last;
  logic [BIN_AW-1:0]  idx_clamp;
  logic [TOT_W:0]     sum_wide;
  logic [TOT_W-1:0]   sum_sat;
  logic               out_free;

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_bin_number      = out_bin_r;
  assign out_bin_total       = out_tot_r;
  assign out_below_low_error = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      low_r   <= '0;
      width_r <= 32'h0001_0000;
      bins_r  <= MAX_CNT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DIR:   dir_r   <= cfg_data[0];
        REG_LOW:   low_r   <= cfg_data;
        REG_WIDTH: width_r <= cfg_data;
        REG_BINS:  bins_r  <= cfg_data[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // sample offset from the low edge, exact in 34 bits
  always_comb begin
    sval = {{2{in_sample_value[31]}}, in_sample_value};
    if (dir_r) sval = -sval;
    lval    = {{2{low_r[31]}}, low_r};
    diff    = sval - lval;
    // round half up: (2*diff + w) / (2*w)
    div_num = {diff[NUM_W-2:0], 1'b0} + {2'b00, width_r};
    div_den = {width_r, 1'b0};
  end

  always_comb begin
    n_act = bins_r;
    if (bins_r == '0) n_act = CNT_W'(1);
    else if (bins_r > MAX_CNT) n_act = MAX_CNT;
    n_last = n_act - 1'b1;
    // a zero width divides to all ones and lands on the last bin here
    if (div_quo >= {{(NUM_W-CNT_W){1'b0}}, n_act}) idx_clamp = n_last[BIN_AW-1:0];
    else idx_clamp = div_quo[BIN_AW-1:0];
  end

  always_comb begin
    sum_wide = {1'b0, rd_data_r} + {{(TOT_W-31){1'b0}}, w_r};
    sum_sat  = (sum_wide > TOT_MAX) ? {TOT_W{1'b1}} : sum_wide[TOT_W-1:0];
  end

  whb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    acc_nxt       = acc_r;
    report_nxt    = report_r;
    w_nxt         = w_r;
    res_bin_nxt   = res_bin_r;
    res_tot_nxt   = res_tot_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bin_nxt   = out_bin_r;
    out_tot_nxt   = out_tot_r;
    out_err_nxt   = out_err_r;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    mem_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_bin_nxt = '0;
          res_tot_nxt = '0;
          res_err_nxt = 1'b0;
          w_nxt       = in_sample_weight;
          case (cmd_t'(in_command))
            CMD_ACC: begin
              acc_nxt = 1'b1;
              if (diff[33]) begin
                res_err_nxt = 1'b1;
                state_nxt   = ST_DONE;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            CMD_CLR: begin
              addr_nxt   = '0;
              report_nxt = 1'b1;
              state_nxt  = ST_CLR;
            end
            CMD_READ: begin
              acc_nxt   = 1'b0;
              addr_nxt  = in_read_index[BIN_AW-1:0];
              state_nxt = ST_RD;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          addr_nxt  = idx_clamp;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        res_bin_nxt = addr_r;
        if (acc_r) begin
          mem_we      = 1'b1;
          mem_wdata   = sum_sat;
          res_tot_nxt = sum_sat;
        end else begin
          res_tot_nxt = rd_data_r;
        end
        state_nxt = ST_DONE;
      end
      ST_CLR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_BIN) begin
          state_nxt = report_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = res_bin_r;
          out_tot_nxt   = res_tot_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;   // clearing sweep after reset, no result
      addr_r      <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r     <= acc_nxt;
    w_r       <= w_nxt;
    res_bin_r <= res_bin_nxt;
    res_tot_r <= res_tot_nxt;
    res_err_r <= res_err_nxt;
    out_bin_r <= out_bin_nxt;
    out_tot_r <= out_tot_nxt;
    out_err_r <= out_err_nxt;
  end

  // one access per cycle; an item finishes its write before the next read
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_r] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[addr_r];
  end

  `CHK_NEXT(a_div_to_rd, (state_r == ST_DIV) && div_done, state_r == ST_RD, "divider end missed")
  `CHK_IMPL(a_idx_range, acc_r && (state_r == ST_RD), {1'b0, addr_r} < n_act, "bin beyond bins in use")
  `CHK_IMPL(a_err_empty, out_valid_r && out_err_r, (out_tot_r == '0) && (out_bin_r == '0), "error word carries data")
  `CHK_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_tot_r), "stalled word lost")

endmodule

// ===== hw/rtl/whb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin index.
// Depends on whb_pkg.
`timescale 1ns / 1ps

module whb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [whb_pkg::NUM_W-1:0] num,
  input  logic [whb_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [whb_pkg::NUM_W-1:0] quo
);
  import whb_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              q_bit;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign q_bit   = (rem_sh >= {1'b0, den_r});
  assign done    = busy_r && (cnt_r == LAST_STEP);
  assign quo     = {num_r[NUM_W-2:0], q_bit};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // remainder stays below den, so the low bits hold it
      rem_nxt = q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_nxt = quo;
      cnt_nxt = cnt_r + 1'b1;
      if (done) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

endmodule
